FILE: rtl/rdeg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdeg_pkg
// Shared widths, register map and hash function for the reuse-distance
// eviction guard.
// ----------------------------------------------------------------------------
package rdeg_pkg;

  localparam int ADDR_W        = 64;
  localparam int TIME_W        = 64;
  localparam int EST_W         = 64;
  localparam int HASH_W        = 32;
  localparam int HASH_SHIFT_LO = 6;
  localparam int HASH_SHIFT_HI = 18;
  localparam int SLOT_OUT_W    = 14;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;

  localparam logic REG_SHORT_REUSE_THRESHOLD = 1'b0;
  localparam logic [EST_W-1:0] THRESHOLD_RESET = 64'd50000000;

  typedef logic [TIME_W-1:0] time_ns_t;
  typedef logic [EST_W-1:0]  est_t;
  typedef logic [HASH_W-1:0] hash_t;

  function automatic hash_t hash_of(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] mix;
    mix = (addr >> HASH_SHIFT_LO) ^ (addr >> HASH_SHIFT_HI);
    return mix[HASH_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/reuse_distance_eviction_guard.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reuse_distance_eviction_guard
// Per-slot averaged reuse-distance tracker that flags blocks to protect.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all SLOT_COUNT entries of
// its slot table (16384 by default); in_ready stays low until it ends, while
// register writes are taken as usual. Each transaction then passes through
// the table read, update, write and result steps of the back engine, which
// takes no new transaction until it is through with the last one. With a
// SLOT_COUNT that is not a power of two the front end reduces the 32-bit hash
// by a reciprocal multiplication in extra multiply and remainder steps, which
// stay hidden behind the back engine, so the throughput is unchanged. A
// result waits in an output register while the next transaction is already
// being accepted and processed.
module reuse_distance_eviction_guard #(
  parameter int SLOT_COUNT = 16384
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rdeg_pkg::ADDR_W-1:0]       in_block_addr,
  input  wire logic [rdeg_pkg::TIME_W-1:0]       in_now_ns,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_protect,
  output logic [rdeg_pkg::EST_W-1:0]             out_reuse_estimate,
  output logic [rdeg_pkg::SLOT_OUT_W-1:0]        out_slot_index,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rdeg_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [rdeg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rdeg_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import rdeg_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int Q_W    = SLOT_W + TIME_W;

  est_t           threshold_r;
  logic           reg_index;
  logic           clear_done;
  logic           fq_valid;
  logic           fq_ready;
  logic [Q_W-1:0] fq_data;
  logic           bq_valid;
  logic           bq_ready;
  logic [Q_W-1:0] bq_data;

  assign pready    = 1'b1;
  assign reg_index = paddr[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_index == REG_SHORT_REUSE_THRESHOLD) begin
        threshold_r <= pwdata;
      end
    end
  end

  always_comb begin
    if (reg_index == REG_SHORT_REUSE_THRESHOLD) begin
      prdata = threshold_r;
    end else begin
      prdata = '0;
    end
  end

  rdeg_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .enable        (clear_done),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_block_addr (in_block_addr),
    .in_now_ns     (in_now_ns),
    .q_valid       (fq_valid),
    .q_ready       (fq_ready),
    .q_data        (fq_data)
  );

  rdeg_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_data)
  );

  rdeg_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .clear_done         (clear_done),
    .q_valid            (bq_valid),
    .q_ready            (bq_ready),
    .q_data             (bq_data),
    .threshold          (threshold_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_protect        (out_protect),
    .out_reuse_estimate (out_reuse_estimate),
    .out_slot_index     (out_slot_index)
  );

endmodule
`default_nettype wire

FILE: rtl/rdeg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdeg_front
// Accepts activation transactions, hashes the address and reduces the hash
// to a table slot, then hands slot and timestamp to the queue.
// ----------------------------------------------------------------------------
module rdeg_front #(
  parameter int SLOT_COUNT = 16384,
  parameter int SLOT_W     = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          enable,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rdeg_pkg::ADDR_W-1:0]   in_block_addr,
  input  wire logic [rdeg_pkg::TIME_W-1:0]   in_now_ns,
  output logic                               q_valid,
  input  wire logic                          q_ready,
  output logic [SLOT_W+rdeg_pkg::TIME_W-1:0] q_data
);
  import rdeg_pkg::*;

  localparam bit              IS_POW2    = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
  localparam int              LOG_N      = $clog2(SLOT_COUNT);
  localparam int              RECIP_SH   = HASH_W + LOG_N;
  localparam int              PROD_W     = 2 * HASH_W + 1;
  localparam logic [63:0]     RECIP_NUM  = 64'd1 << RECIP_SH;
  localparam logic [63:0]     RECIP_FULL =
    (RECIP_NUM + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
  localparam logic [HASH_W:0] RECIP      = RECIP_FULL[HASH_W:0];

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_REM, F_PUSH} front_state_t;

  front_state_t      state_r;
  hash_t             hash_r;
  time_ns_t          now_r;
  hash_t             quot_r;
  logic [SLOT_W-1:0] rem_r;
  logic [PROD_W-1:0] prod;
  hash_t             quot_nxt;
  hash_t             rem_full;
  logic [SLOT_W-1:0] slot;

  assign prod     = PROD_W'(hash_r) * PROD_W'(RECIP);
  assign quot_nxt = hash_t'(prod >> RECIP_SH);
  assign rem_full = hash_r - (quot_r * hash_t'(SLOT_COUNT));

  assign slot     = IS_POW2 ? hash_r[SLOT_W-1:0] : rem_r;
  assign in_ready = enable && (state_r == F_IDLE);
  assign q_valid  = (state_r == F_PUSH);
  assign q_data   = {slot, now_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            hash_r  <= hash_of(in_block_addr);
            now_r   <= in_now_ns;
            state_r <= IS_POW2 ? F_PUSH : F_MUL;
          end
        end
        F_MUL: begin
          quot_r  <= quot_nxt;
          state_r <= F_REM;
        end
        F_REM: begin
          rem_r   <= rem_full[SLOT_W-1:0];
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (q_ready) begin
            state_r <= F_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rdeg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdeg_fifo
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module rdeg_fifo #(
  parameter int WIDTH = 78
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rdeg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdeg_back
// Holds the per-slot table, clears it after reset, performs the
// read-modify-write of each transaction and drives the result register.
// ----------------------------------------------------------------------------
module rdeg_back #(
  parameter int SLOT_COUNT = 16384,
  parameter int SLOT_W     = 14
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  output logic                                   clear_done,
  input  wire logic                              q_valid,
  output logic                                   q_ready,
  input  wire logic [SLOT_W+rdeg_pkg::TIME_W-1:0] q_data,
  input  wire logic [rdeg_pkg::EST_W-1:0]        threshold,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_protect,
  output logic [rdeg_pkg::EST_W-1:0]             out_reuse_estimate,
  output logic [rdeg_pkg::SLOT_OUT_W-1:0]        out_slot_index
);
  import rdeg_pkg::*;

  localparam int ENTRY_W = EST_W + TIME_W;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_CALC, B_WRITE, B_RESULT} back_state_t;

  logic [ENTRY_W-1:0] mem [SLOT_COUNT];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  back_state_t        state_r;
  logic [SLOT_W-1:0]  clr_cnt_r;
  logic [SLOT_W-1:0]  slot_r;
  time_ns_t           now_r;
  logic               upd_r;
  time_ns_t           dist_r;
  est_t               tri_r;
  est_t               avg_old_r;
  est_t               est_r;
  est_t               est_nxt;
  time_ns_t           prev_time;
  est_t               prev_avg;
  logic               out_valid_r;
  logic               out_protect_r;
  est_t               out_est_r;
  logic [SLOT_W-1:0]  out_slot_r;

  assign prev_time = rd_data_r[TIME_W-1:0];
  assign prev_avg  = rd_data_r[ENTRY_W-1:TIME_W];
  assign est_nxt   = upd_r ? ((tri_r + dist_r) >> 2) : avg_old_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = {est_nxt, now_r};
    if (state_r == B_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (state_r == B_WRITE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[slot_r];
  end

  assign clear_done         = (state_r != B_CLEAR);
  assign q_ready            = (state_r == B_IDLE);
  assign out_valid          = out_valid_r;
  assign out_protect        = out_protect_r;
  assign out_reuse_estimate = out_est_r;
  assign out_slot_index     = SLOT_OUT_W'(out_slot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != B_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == SLOT_W'(SLOT_COUNT - 1)) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            slot_r  <= q_data[SLOT_W+TIME_W-1:TIME_W];
            now_r   <= q_data[TIME_W-1:0];
            state_r <= B_READ;
          end
        end
        B_READ: begin
          state_r <= B_CALC;
        end
        B_CALC: begin
          upd_r     <= (prev_time != '0) && (now_r > prev_time);
          dist_r    <= now_r - prev_time;
          tri_r     <= {prev_avg[EST_W-2:0], 1'b0} + prev_avg;
          avg_old_r <= prev_avg;
          state_r   <= B_WRITE;
        end
        B_WRITE: begin
          est_r   <= est_nxt;
          state_r <= B_RESULT;
        end
        B_RESULT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_protect_r <= (est_r != '0) && (est_r < threshold);
            out_est_r     <= est_r;
            out_slot_r    <= slot_r;
            state_r       <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
